>>> rtl/smau_pkg.sv
`default_nettype none

package smau_pkg;

  localparam int unsigned MAX_DIM_DEF    = 8;
  localparam int unsigned VALUE_BITS_DEF = 32;

  localparam int unsigned CMD_W      = 2;
  localparam int unsigned POS_W      = 3;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned DIM_REG_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned TDATA_W    = 40;
  localparam int unsigned ROW_LSB    = 0;
  localparam int unsigned COL_LSB    = ROW_LSB + POS_W;
  localparam int unsigned VAL_LSB    = COL_LSB + POS_W;
  localparam int unsigned FRAC_BITS  = 16;

  localparam logic [CMD_W-1:0] CMD_LOAD_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN    = 2'd2;

  localparam logic [OP_W-1:0] OP_MUL   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB   = 3'd2;
  localparam logic [OP_W-1:0] OP_TRANS = 3'd3;
  localparam logic [OP_W-1:0] OP_SCALE = 3'd4;
  localparam logic [OP_W-1:0] OP_DIAG  = 3'd5;

  localparam logic [CFG_IDX_W-1:0] REG_OPERATION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE     = 3'd5;

  localparam logic [DIM_REG_W-1:0] DIM_RESET   = 4'd1;
  localparam logic [DATA_W-1:0]    SCALE_RESET = 32'h0001_0000;

endpackage

`default_nettype wire

>>> rtl/smau_ram.sv
`default_nettype none

module smau_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> rtl/small_matrix_arith_unit_top.sv
// Fixed-point matrix unit holding two row-major Q16.16 matrices A and B of up to MAX_DIM by
// MAX_DIM elements, each in its own single-port-read memory. A load request (tuser 0 for A,
// 1 for B) writes one element. A run request (tuser 2) performs the operation in the
// operation register and streams every result element in row-major order with its
// coordinates, tlast on the final one; a size mismatch returns one output beat with status 1
// and tlast. Each result element goes through a read, multiply-and-round or add/sub/copy,
// accumulate and saturate path; the next element starts only after the previous one has
// left the output register. Setting the diagonal first writes the value one into the first
// min(rows_a, cols_a) diagonal elements of A. The input accepts no request while a run is
// busy.
`default_nettype none

module small_matrix_arith_unit_top
  import smau_pkg::*;
#(
  parameter int unsigned MAX_DIM    = MAX_DIM_DEF,
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DATA_W-1:0]    cfg_data_i,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0: row[2:0], col[5:3], element_value[37:6], zero fill.
  input  wire logic [TDATA_W-1:0]   s_axis_tdata,
  // Fields from bit 0: command[1:0].
  input  wire logic [CMD_W-1:0]     s_axis_tuser,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // Fields from bit 0: out_row[2:0], out_col[5:3], out_value[37:6], zero fill.
  output logic      [TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: status[0].
  output logic                      m_axis_tuser,
  output logic                      m_axis_tlast
);

  localparam int unsigned SAT_BITS = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int unsigned PROD_W   = SAT_BITS + DATA_W;
  localparam int unsigned RND_W    = PROD_W - FRAC_BITS;
  localparam int unsigned ACC_W    = RND_W + $clog2(MAX_DIM) + 1;
  localparam int unsigned IDX_W    = $clog2(MAX_DIM);
  localparam int unsigned DIM_W    = $clog2(MAX_DIM + 1);
  localparam int unsigned DEPTH    = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W   = $clog2(DEPTH);
  localparam int unsigned ONE_Q    = 1 << FRAC_BITS;
  localparam int unsigned HALF_Q   = 1 << (FRAC_BITS - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - SAT_BITS + 1){1'b0}}, {(SAT_BITS - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO =
    {{(ACC_W - SAT_BITS + 1){1'b1}}, {(SAT_BITS - 1){1'b0}}};
  localparam logic [SAT_BITS-1:0] ONE_SAT =
    (SAT_BITS > FRAC_BITS + 1) ? SAT_BITS'(ONE_Q) : SAT_HI[SAT_BITS-1:0];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIAG,
    ST_ISSUE,
    ST_WAIT,
    ST_ERR
  } state_e;

  function automatic logic [SAT_BITS-1:0] sat_fn(input logic signed [ACC_W-1:0] v);
    logic [SAT_BITS-1:0] res;
    if (v > SAT_HI) begin
      res = SAT_HI[SAT_BITS-1:0];
    end else if (v < SAT_LO) begin
      res = SAT_LO[SAT_BITS-1:0];
    end else begin
      res = v[SAT_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
    logic [DIM_W-1:0] res;
    if (d == '0) begin
      res = DIM_W'(1);
    end else if (int'(d) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(d);
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] addr_fn(input logic [IDX_W-1:0] r,
                                                input logic [IDX_W-1:0] c);
    return ADDR_W'(int'(r) * MAX_DIM + int'(c));
  endfunction

  // Configuration registers.
  logic [OP_W-1:0]          op_q;
  logic [DIM_REG_W-1:0]     rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic signed [DATA_W-1:0] scale_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q     <= OP_MUL;
      rows_a_q <= DIM_RESET;
      cols_a_q <= DIM_RESET;
      rows_b_q <= DIM_RESET;
      cols_b_q <= DIM_RESET;
      scale_q  <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_OPERATION: op_q     <= cfg_data_i[OP_W-1:0];
        REG_ROWS_A:    rows_a_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_COLS_A:    cols_a_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_ROWS_B:    rows_b_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_COLS_B:    cols_b_q <= cfg_data_i[DIM_REG_W-1:0];
        REG_SCALE:     scale_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [DIM_W-1:0] ra, ca, rb, cb, min_dim;
  logic [DIM_W-1:0] n_rows, n_cols, n_inner;
  logic             op_mul_like, op_write_back;

  assign ra      = eff_dim(rows_a_q);
  assign ca      = eff_dim(cols_a_q);
  assign rb      = eff_dim(rows_b_q);
  assign cb      = eff_dim(cols_b_q);
  assign min_dim = (ra < ca) ? ra : ca;

  assign op_mul_like   = (op_q == OP_MUL) || (op_q == OP_SCALE);
  assign op_write_back = (op_q == OP_ADD) || (op_q == OP_SUB) || (op_q == OP_SCALE);

  always_comb begin
    n_rows  = ra;
    n_cols  = ca;
    n_inner = DIM_W'(1);
    case (op_q)
      OP_MUL: begin
        n_cols  = cb;
        n_inner = ca;
      end
      OP_TRANS: begin
        n_rows = ca;
        n_cols = ra;
      end
      default: ;
    endcase
  end

  // Input fields.
  logic [POS_W-1:0]         in_row, in_col;
  logic signed [DATA_W-1:0] in_val;
  logic                     in_pos_ok;
  logic [ADDR_W-1:0]        in_addr;

  assign in_row    = s_axis_tdata[ROW_LSB +: POS_W];
  assign in_col    = s_axis_tdata[COL_LSB +: POS_W];
  assign in_val    = $signed(s_axis_tdata[VAL_LSB +: DATA_W]);
  assign in_pos_ok = (int'(in_row) < MAX_DIM) && (int'(in_col) < MAX_DIM);
  assign in_addr   = ADDR_W'(int'(in_row) * MAX_DIM + int'(in_col));

  // Memories.
  logic                a_we, b_we;
  logic [ADDR_W-1:0]   a_waddr, b_waddr, a_raddr, b_raddr;
  logic [SAT_BITS-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  smau_ram #(
    .WIDTH (SAT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  smau_ram #(
    .WIDTH (SAT_BITS),
    .DEPTH (DEPTH)
  ) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // Sequencer and output register.
  state_e           state_q, state_d;
  logic [IDX_W-1:0] r_q, r_d, c_q, c_d, i_q, i_d;
  logic             inflight_q, inflight_d;
  logic             m_valid_q, m_valid_d;
  logic [POS_W-1:0] m_row_q, m_row_d, m_col_q, m_col_d;
  logic [DATA_W-1:0] m_value_q, m_value_d;
  logic             m_status_q, m_status_d, m_last_q, m_last_d;

  logic issue, start_ok, is_first, is_lastd, is_laste, last_c, last_r;

  // Pipeline: s1 has memory data, s2 holds the product or the add/sub/copy result, s3 holds the accumulator.
  logic             s1_vld_q, s2_vld_q, s3_vld_q;
  logic [IDX_W-1:0] s1_r_q, s1_c_q, s2_r_q, s2_c_q, s3_r_q, s3_c_q;
  logic             s1_first_q, s1_lastd_q, s1_laste_q;
  logic             s2_first_q, s2_lastd_q, s2_laste_q;
  logic             s3_lastd_q, s3_laste_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [SAT_BITS:0]   lin_q, lin_d;
  logic signed [ACC_W-1:0]    acc_q, term;
  logic signed [SAT_BITS-1:0] a_s, b_s;
  logic signed [DATA_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   rnd_sum;
  logic signed [RND_W-1:0]    rnd_val;
  logic [SAT_BITS-1:0]        res_sat;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign start_ok      = !inflight_q && (!m_valid_q || m_axis_tready);
  assign is_first      = (i_q == '0);
  assign is_lastd      = (DIM_W'(i_q) + DIM_W'(1) == n_inner);
  assign last_c        = (DIM_W'(c_q) + DIM_W'(1) == n_cols);
  assign last_r        = (DIM_W'(r_q) + DIM_W'(1) == n_rows);
  assign is_laste      = is_lastd && last_c && last_r;
  assign res_sat       = sat_fn(acc_q);

  always_comb begin
    a_raddr = addr_fn(r_q, c_q);
    b_raddr = addr_fn(r_q, c_q);
    case (op_q)
      OP_MUL: begin
        a_raddr = addr_fn(r_q, i_q);
        b_raddr = addr_fn(i_q, c_q);
      end
      OP_TRANS: a_raddr = addr_fn(c_q, r_q);
      default: ;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    r_d        = r_q;
    c_d        = c_q;
    i_d        = i_q;
    inflight_d = inflight_q;
    m_valid_d  = m_valid_q;
    m_row_d    = m_row_q;
    m_col_d    = m_col_q;
    m_value_d  = m_value_q;
    m_status_d = m_status_q;
    m_last_d   = m_last_q;
    a_we       = 1'b0;
    a_waddr    = in_addr;
    a_wdata    = sat_fn(ACC_W'(in_val));
    b_we       = 1'b0;
    b_waddr    = in_addr;
    b_wdata    = sat_fn(ACC_W'(in_val));
    issue      = 1'b0;

    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    if (s3_vld_q && s3_lastd_q) begin
      m_valid_d  = 1'b1;
      m_row_d    = POS_W'(s3_r_q);
      m_col_d    = POS_W'(s3_c_q);
      m_value_d  = DATA_W'($signed(res_sat));
      m_status_d = 1'b0;
      m_last_d   = s3_laste_q;
      inflight_d = 1'b0;
      if (op_write_back) begin
        a_we    = 1'b1;
        a_waddr = addr_fn(s3_r_q, s3_c_q);
        a_wdata = res_sat;
      end
    end

    case (state_q)
      ST_IDLE: begin
        r_d = '0;
        c_d = '0;
        i_d = '0;
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            CMD_LOAD_A: a_we = in_pos_ok;
            CMD_LOAD_B: b_we = in_pos_ok;
            CMD_RUN: begin
              case (op_q)
                OP_MUL:             state_d = (ca == rb) ? ST_ISSUE : ST_ERR;
                OP_ADD, OP_SUB:     state_d = (ra == rb && ca == cb) ? ST_ISSUE : ST_ERR;
                OP_TRANS, OP_SCALE: state_d = ST_ISSUE;
                OP_DIAG:            state_d = ST_DIAG;
                default: ;
              endcase
            end
            default: ;
          endcase
        end
      end
      ST_DIAG: begin
        a_we    = 1'b1;
        a_waddr = addr_fn(i_q, i_q);
        a_wdata = ONE_SAT;
        if (DIM_W'(i_q) + DIM_W'(1) == min_dim) begin
          i_d     = '0;
          state_d = ST_ISSUE;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_ISSUE: begin
        if (!is_first || start_ok) begin
          issue = 1'b1;
          if (is_first) begin
            inflight_d = 1'b1;
          end
          if (!is_lastd) begin
            i_d = i_q + IDX_W'(1);
          end else begin
            i_d = '0;
            if (!last_c) begin
              c_d = c_q + IDX_W'(1);
            end else begin
              c_d = '0;
              if (last_r) begin
                state_d = ST_WAIT;
              end else begin
                r_d = r_q + IDX_W'(1);
              end
            end
          end
        end
      end
      ST_WAIT: begin
        if (!inflight_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d  = 1'b1;
          m_row_d    = '0;
          m_col_d    = '0;
          m_value_d  = '0;
          m_status_d = 1'b1;
          m_last_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      r_q        <= '0;
      c_q        <= '0;
      i_q        <= '0;
      inflight_q <= 1'b0;
      m_valid_q  <= 1'b0;
      m_row_q    <= '0;
      m_col_q    <= '0;
      m_value_q  <= '0;
      m_status_q <= 1'b0;
      m_last_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      r_q        <= r_d;
      c_q        <= c_d;
      i_q        <= i_d;
      inflight_q <= inflight_d;
      m_valid_q  <= m_valid_d;
      m_row_q    <= m_row_d;
      m_col_q    <= m_col_d;
      m_value_q  <= m_value_d;
      m_status_q <= m_status_d;
      m_last_q   <= m_last_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = TDATA_W'({m_value_q, m_col_q, m_row_q});
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tlast  = m_last_q;

  // Datapath.
  assign a_s   = $signed(a_rdata);
  assign b_s   = $signed(b_rdata);
  assign mul_b = (op_q == OP_SCALE) ? scale_q : DATA_W'(b_s);

  always_comb begin
    case (op_q)
      OP_ADD:  lin_d = (SAT_BITS + 1)'(a_s) + (SAT_BITS + 1)'(b_s);
      OP_SUB:  lin_d = (SAT_BITS + 1)'(a_s) - (SAT_BITS + 1)'(b_s);
      default: lin_d = (SAT_BITS + 1)'(a_s);
    endcase
  end

  assign rnd_sum = prod_q + PROD_W'(HALF_Q);
  assign rnd_val = $signed(rnd_sum[PROD_W-1:FRAC_BITS]);
  assign term    = op_mul_like ? ACC_W'(rnd_val) : ACC_W'(lin_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_r_q     <= r_q;
    s1_c_q     <= c_q;
    s1_first_q <= is_first;
    s1_lastd_q <= is_lastd;
    s1_laste_q <= is_laste;
    s2_r_q     <= s1_r_q;
    s2_c_q     <= s1_c_q;
    s2_first_q <= s1_first_q;
    s2_lastd_q <= s1_lastd_q;
    s2_laste_q <= s1_laste_q;
    prod_q     <= a_s * mul_b;
    lin_q      <= lin_d;
    s3_r_q     <= s2_r_q;
    s3_c_q     <= s2_c_q;
    s3_lastd_q <= s2_lastd_q;
    s3_laste_q <= s2_laste_q;
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? term : acc_q + term;
    end
  end

endmodule

`default_nettype wire
